>>> rtl/psg_fs_pkg.sv
// Shared types, register addresses, command codes and tables of the frame sequencer.
`timescale 1ns / 1ps

package psg_fs_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_ONE,
        S_MVOL,
        S_WAVE,
        S_NCTRL,
        S_DMUL,
        S_DRUN,
        S_DEMIT,
        S_TRIG,
        S_TVOL,
        S_TNRST,
        S_TCTRL,
        S_TLEN,
        S_ENV,
        S_EVOL,
        S_SWEEP,
        S_TEND
    } state_t;

    // command targets
    localparam logic [2:0] TGT_PERIOD = 3'd0;
    localparam logic [2:0] TGT_VOLUME = 3'd1;
    localparam logic [2:0] TGT_CHCTRL = 3'd2;
    localparam logic [2:0] TGT_NCTRL  = 3'd3;
    localparam logic [2:0] TGT_NRESET = 3'd4;
    localparam logic [2:0] TGT_OUTEN  = 3'd5;
    localparam logic [2:0] TGT_WAVE   = 3'd6;

    // emulated register addresses
    localparam logic [5:0] A_SWEEP  = 6'h00;
    localparam logic [5:0] A_LEN0   = 6'h01;
    localparam logic [5:0] A_ENV0   = 6'h02;
    localparam logic [5:0] A_PLO0   = 6'h03;
    localparam logic [5:0] A_PHI0   = 6'h04;
    localparam logic [5:0] A_LEN1   = 6'h06;
    localparam logic [5:0] A_ENV1   = 6'h07;
    localparam logic [5:0] A_PLO1   = 6'h08;
    localparam logic [5:0] A_PHI1   = 6'h09;
    localparam logic [5:0] A_ENV2   = 6'h0A;
    localparam logic [5:0] A_LEN2   = 6'h0B;
    localparam logic [5:0] A_WLVL   = 6'h0C;
    localparam logic [5:0] A_PLO2   = 6'h0D;
    localparam logic [5:0] A_PHI2   = 6'h0E;
    localparam logic [5:0] A_LEN3   = 6'h10;
    localparam logic [5:0] A_ENV3   = 6'h11;
    localparam logic [5:0] A_NPOLY  = 6'h12;
    localparam logic [5:0] A_NGO    = 6'h13;
    localparam logic [5:0] A_MVOL   = 6'h14;
    localparam logic [5:0] A_PAN    = 6'h15;
    localparam logic [5:0] A_ENABLE = 6'h16;

    localparam logic [20:0] MUL_PERIOD = 21'd1536000;
    localparam logic [20:0] MUL_NOISE  = 21'd1500;
    localparam logic [23:0] SRC_CLK_RESET = 24'd4194304;

    function automatic logic [7:0] duty_byte(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] pat;
        case (sel)
            2'd0:    pat = 8'b0111_1111;
            2'd1:    pat = 8'b0111_1110;
            2'd2:    pat = 8'b0001_1110;
            default: pat = 8'b1000_0001;
        endcase
        duty_byte = pat[pos] ? 8'hFF : 8'h00;
    endfunction

    function automatic logic [3:0] wave_vol(input logic [1:0] lvl);
        case (lvl)
            2'd0:    wave_vol = 4'd0;
            2'd1:    wave_vol = 4'd15;
            2'd2:    wave_vol = 4'd7;
            default: wave_vol = 4'd3;
        endcase
    endfunction

    function automatic logic [3:0] noise_scale(input logic [2:0] sel);
        noise_scale = (sel == 3'd0) ? 4'd1 : {sel, 1'b0};
    endfunction

    // right | left << 4, each (vol * master + 6) >> 3
    function automatic logic [15:0] vol_mix(input logic [7:0] master, input logic [7:0] pan,
                                            input logic [3:0] vol, input logic [1:0] ch);
        logic [2:0] mr;
        logic [2:0] ml;
        logic [7:0] r;
        logic [7:0] l;
        mr = pan[ch] ? master[2:0] : 3'd0;
        ml = pan[{1'b1, ch}] ? master[6:4] : 3'd0;
        r  = 8'(vol * mr) + 8'd6;
        l  = 8'(vol * ml) + 8'd6;
        vol_mix = {8'h00, l[6:3], r[6:3]};
    endfunction

endpackage

>>> rtl/psg_register_frame_sequencer.sv
// Register-write translator and frame sequencer of the four-channel sound chip.
`timescale 1ns / 1ps

// Takes one item at a time: a register write or a frame-sequencer tick, and
// emits its commands in order through a single output register, with
// last set on the final one. in_stall stays high until the item's last
// command has been loaded; the next item can be accepted in the cycle after.
// A write that only updates a register emits no command. A master volume or
// pan write emits one volume command per channel. A duty write emits 16 wave
// bytes; a noise trigger emits volume, noise reset and channel control. A
// period write uses the shared restoring divider: a load step and 32 steps,
// then the period command and, with a trigger, the trigger commands. A noise
// divider write emits the noise control command, then runs the divider. A
// tick ends with a channel control command. On every 4th tick the envelopes
// step. A tick that applies a sweep step also runs the divider. Output
// stalls hold the item.
module psg_register_frame_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [5:0]  reg_addr,
    input  logic [7:0]  reg_data,
    input  logic [7:0]  channel_ctrl_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  target,
    output logic [1:0]  channel,
    output logic [5:0]  wave_offset,
    output logic [15:0] value,
    output logic        last
);

    psg_fs_pkg::state_t state_reg, state_next;

    logic [23:0] src_clk_reg;
    logic        op_reg;
    logic [5:0]  addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  act_reg;
    logic [1:0]  ch_reg;
    logic [3:0]  idx_reg;

    logic [7:0]  sweep_set_reg;
    logic [7:0]  len_set_reg [4];
    logic [7:0]  env_set_reg [4];
    logic [7:0]  per_lo_reg  [3];
    logic [7:0]  per_hi_reg  [3];
    logic [7:0]  noise_go_reg;
    logic [7:0]  wave_lvl_reg;
    logic [7:0]  pan_reg;
    logic [7:0]  master_reg;
    logic [7:0]  len_cnt_reg [4];
    logic [3:0]  vol_reg     [4];
    logic [2:0]  env_cnt_reg [4];
    logic [2:0]  sweep_cnt_reg;
    logic [1:0]  phase_reg;

    logic [21:0] rem_reg;
    logic [31:0] quo_reg;
    logic [21:0] den_reg;
    logic [4:0]  dcnt_reg;

    logic        out_valid_reg;
    logic [2:0]  tgt_reg;
    logic [1:0]  och_reg;
    logic [5:0]  off_reg;
    logic [15:0] val_reg;
    logic        last_reg;

    logic        emit_req;
    logic        emit_fire;
    logic [2:0]  e_tgt;
    logic [1:0]  e_ch;
    logic [5:0]  e_off;
    logic [15:0] e_val;
    logic        e_last;

    logic        is_phi;
    logic        is_noise_div;
    logic [1:0]  dec_ch;
    logic [10:0] p_sel;
    logic [15:0] div_res;

    // divider step
    logic [22:0] rem_sh;
    logic        rem_ge;
    logic [21:0] rem_step;

    // shared multiplier feeding the divider
    logic [20:0] mul_a;
    logic [18:0] mul_b;
    logic [39:0] mul_p;

    // length tick
    logic [7:0]  lc_new [4];
    logic [7:0]  act_tl;

    // envelope
    logic [7:0]  en_sel;
    logic [2:0]  cnt1;
    logic        env_act;
    logic        env_match;
    logic        env_up;
    logic        env_dn;
    logic        env_emit;
    logic [1:0]  env_next_ch;

    // sweep
    logic [10:0] sw_p;
    logic [10:0] sw_d;
    logic [11:0] sw_np;
    logic        sw_on;
    logic        sw_over;
    logic [2:0]  sc1;
    logic        sw_match;

    assign in_stall    = (state_reg != psg_fs_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign target      = tgt_reg;
    assign channel     = och_reg;
    assign wave_offset = off_reg;
    assign value       = val_reg;
    assign last        = last_reg;

    assign emit_fire = emit_req && (!out_valid_reg || !out_stall);

    assign is_phi = (addr_reg == psg_fs_pkg::A_PHI0) || (addr_reg == psg_fs_pkg::A_PHI1)
                 || (addr_reg == psg_fs_pkg::A_PHI2);
    assign is_noise_div = !op_reg && (addr_reg == psg_fs_pkg::A_NPOLY);

    always_comb
    begin
        case (addr_reg)
            psg_fs_pkg::A_LEN1, psg_fs_pkg::A_PLO1, psg_fs_pkg::A_PHI1: dec_ch = 2'd1;
            psg_fs_pkg::A_PLO2, psg_fs_pkg::A_PHI2:                     dec_ch = 2'd2;
            psg_fs_pkg::A_NPOLY, psg_fs_pkg::A_NGO:                     dec_ch = 2'd3;
            default:                                                    dec_ch = 2'd0;
        endcase
    end

    always_comb
    begin
        case (ch_reg)
            2'd0:    p_sel = {per_hi_reg[0][2:0], per_lo_reg[0]};
            2'd1:    p_sel = {per_hi_reg[1][2:0], per_lo_reg[1]};
            2'd2:    p_sel = {per_hi_reg[2][2:0], per_lo_reg[2]};
            default: p_sel = 11'd0;
        endcase
    end

    always_comb
    begin
        if (is_noise_div)
        begin
            mul_a = psg_fs_pkg::MUL_NOISE;
            mul_b = 19'(psg_fs_pkg::noise_scale(data_reg[2:0])) << data_reg[7:4];
        end
        else
        begin
            mul_a = psg_fs_pkg::MUL_PERIOD;
            mul_b = {7'd0, 12'(12'd2048 - {1'b0, p_sel})};
        end
        mul_p = mul_a * mul_b;
    end

    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_step = rem_ge ? 22'(rem_sh - {1'b0, den_reg}) : rem_sh[21:0];
    // saturate; a zero divisor also saturates
    assign div_res  = ((den_reg == 22'd0) || (quo_reg[31:16] != 16'd0)) ? 16'hFFFF
                      : quo_reg[15:0];

    always_comb
    begin
        act_tl = act_reg;
        for (int i = 0; i < 4; i++)
        begin
            logic [7:0] en;
            logic [7:0] inc;
            logic       run;
            en  = (i == 3) ? noise_go_reg : per_hi_reg[i];
            inc = len_cnt_reg[i] + 8'd1;
            run = act_reg[i] && en[6];
            lc_new[i] = len_cnt_reg[i];
            if (run && (len_cnt_reg[i] != 8'd0))
                lc_new[i] = (i == 2) ? inc : {2'b00, inc[5:0]};
            if (run && (lc_new[i] == 8'd0))
                act_tl[i] = 1'b0;
        end
    end

    assign en_sel      = env_set_reg[ch_reg];
    assign cnt1        = env_cnt_reg[ch_reg] + 3'd1;
    assign env_act     = act_reg[ch_reg] && (en_sel[2:0] != 3'd0);
    assign env_match   = cnt1 == en_sel[2:0];
    assign env_up      = en_sel[3] && (vol_reg[ch_reg] != 4'd15);
    assign env_dn      = !en_sel[3] && (vol_reg[ch_reg] != 4'd0);
    assign env_emit    = env_act && env_match && (env_up || env_dn);
    assign env_next_ch = (ch_reg == 2'd0) ? 2'd1 : 2'd3;

    assign sw_p     = {per_hi_reg[0][2:0], per_lo_reg[0]};
    assign sw_d     = sw_p >> sweep_set_reg[2:0];
    assign sw_np    = sweep_set_reg[3] ? 12'({1'b0, sw_p} - {1'b0, sw_d})
                                       : 12'({1'b0, sw_p} + {1'b0, sw_d});
    assign sw_over  = sw_np[11];
    assign sw_on    = !phase_reg[0] && (sweep_set_reg[6:4] != 3'd0);
    assign sc1      = sweep_cnt_reg + 3'd1;
    assign sw_match = sc1 == sweep_set_reg[6:4];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psg_fs_pkg::S_IDLE:
                if (in_valid)
                    state_next = psg_fs_pkg::S_DEC;
            psg_fs_pkg::S_DEC:
                if (op_reg)
                    state_next = psg_fs_pkg::S_TLEN;
                else
                begin
                    case (addr_reg)
                        psg_fs_pkg::A_ENABLE:
                            state_next = psg_fs_pkg::S_ONE;
                        psg_fs_pkg::A_MVOL, psg_fs_pkg::A_PAN:
                            state_next = psg_fs_pkg::S_MVOL;
                        psg_fs_pkg::A_LEN0, psg_fs_pkg::A_LEN1:
                            state_next = psg_fs_pkg::S_WAVE;
                        psg_fs_pkg::A_PLO0, psg_fs_pkg::A_PLO1, psg_fs_pkg::A_PLO2,
                        psg_fs_pkg::A_PHI0, psg_fs_pkg::A_PHI1, psg_fs_pkg::A_PHI2:
                            state_next = psg_fs_pkg::S_DMUL;
                        psg_fs_pkg::A_NPOLY:
                            state_next = psg_fs_pkg::S_NCTRL;
                        psg_fs_pkg::A_NGO:
                            state_next = data_reg[7] ? psg_fs_pkg::S_TRIG : psg_fs_pkg::S_IDLE;
                        default:
                            state_next = (addr_reg[5:4] == 2'b10) ? psg_fs_pkg::S_ONE
                                                                  : psg_fs_pkg::S_IDLE;
                    endcase
                end
            psg_fs_pkg::S_ONE:
                if (emit_fire)
                    state_next = psg_fs_pkg::S_IDLE;
            psg_fs_pkg::S_MVOL:
                if (emit_fire && (ch_reg == 2'd3))
                    state_next = psg_fs_pkg::S_IDLE;
            psg_fs_pkg::S_WAVE:
                if (emit_fire && (idx_reg == 4'd15))
                    state_next = psg_fs_pkg::S_IDLE;
            psg_fs_pkg::S_NCTRL:
                if (emit_fire)
                    state_next = psg_fs_pkg::S_DMUL;
            psg_fs_pkg::S_DMUL:
                state_next = psg_fs_pkg::S_DRUN;
            psg_fs_pkg::S_DRUN:
                if (dcnt_reg == 5'd31)
                    state_next = psg_fs_pkg::S_DEMIT;
            psg_fs_pkg::S_DEMIT:
                if (emit_fire)
                begin
                    if (op_reg)
                        state_next = psg_fs_pkg::S_TEND;
                    else if (is_phi && data_reg[7])
                        state_next = psg_fs_pkg::S_TRIG;
                    else
                        state_next = psg_fs_pkg::S_IDLE;
                end
            psg_fs_pkg::S_TRIG:
                state_next = psg_fs_pkg::S_TVOL;
            psg_fs_pkg::S_TVOL:
                if (emit_fire)
                    state_next = (ch_reg == 2'd3) ? psg_fs_pkg::S_TNRST : psg_fs_pkg::S_TCTRL;
            psg_fs_pkg::S_TNRST:
                if (emit_fire)
                    state_next = psg_fs_pkg::S_TCTRL;
            psg_fs_pkg::S_TCTRL:
                if (emit_fire)
                    state_next = psg_fs_pkg::S_IDLE;
            psg_fs_pkg::S_TLEN:
                state_next = (phase_reg == 2'd0) ? psg_fs_pkg::S_ENV : psg_fs_pkg::S_SWEEP;
            psg_fs_pkg::S_ENV:
                if (env_emit)
                    state_next = psg_fs_pkg::S_EVOL;
                else if (ch_reg == 2'd3)
                    state_next = psg_fs_pkg::S_SWEEP;
            psg_fs_pkg::S_EVOL:
                if (emit_fire)
                    state_next = (ch_reg == 2'd3) ? psg_fs_pkg::S_SWEEP : psg_fs_pkg::S_ENV;
            psg_fs_pkg::S_SWEEP:
                state_next = (sw_on && sw_match && !sw_over) ? psg_fs_pkg::S_DMUL
                                                             : psg_fs_pkg::S_TEND;
            psg_fs_pkg::S_TEND:
                if (emit_fire)
                    state_next = psg_fs_pkg::S_IDLE;
            default:
                state_next = psg_fs_pkg::S_IDLE;
        endcase
    end

    // command for the current state
    always_comb
    begin
        emit_req = 1'b0;
        e_tgt    = psg_fs_pkg::TGT_PERIOD;
        e_ch     = ch_reg;
        e_off    = 6'd0;
        e_val    = 16'd0;
        e_last   = 1'b0;
        case (state_reg)
            psg_fs_pkg::S_ONE:
            begin
                emit_req = 1'b1;
                e_last   = 1'b1;
                if (addr_reg == psg_fs_pkg::A_ENABLE)
                begin
                    e_tgt = psg_fs_pkg::TGT_OUTEN;
                    e_ch  = 2'd0;
                    e_val = {15'd0, data_reg[7]};
                end
                else
                begin
                    e_tgt = psg_fs_pkg::TGT_WAVE;
                    e_ch  = 2'd2;
                    e_off = addr_reg;
                    e_val = {8'h00, data_reg[3:0], data_reg[7:4]};
                end
            end
            psg_fs_pkg::S_MVOL, psg_fs_pkg::S_TVOL, psg_fs_pkg::S_EVOL:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_VOLUME;
                e_val    = psg_fs_pkg::vol_mix(master_reg, pan_reg, vol_reg[ch_reg], ch_reg);
                e_last   = (state_reg == psg_fs_pkg::S_MVOL) && (ch_reg == 2'd3);
            end
            psg_fs_pkg::S_WAVE:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_WAVE;
                e_off    = {ch_reg, idx_reg};
                e_val    = {8'h00, psg_fs_pkg::duty_byte(data_reg[7:6], idx_reg[2:0])};
                e_last   = idx_reg == 4'd15;
            end
            psg_fs_pkg::S_NCTRL:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_NCTRL;
                e_val    = {11'd0, 1'b1, 3'd0, data_reg[3]};
            end
            psg_fs_pkg::S_DEMIT:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_PERIOD;
                e_val    = 16'(16'd0 - div_res);
                e_last   = !op_reg && !(is_phi && data_reg[7]);
            end
            psg_fs_pkg::S_TNRST:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_NRESET;
            end
            psg_fs_pkg::S_TCTRL:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_CHCTRL;
                e_val    = {8'h00, act_reg | (8'd1 << ch_reg)
                                   | ((ch_reg == 2'd3) ? 8'h80 : 8'h00)};
                e_last   = 1'b1;
            end
            psg_fs_pkg::S_TEND:
            begin
                emit_req = 1'b1;
                e_tgt    = psg_fs_pkg::TGT_CHCTRL;
                e_ch     = 2'd0;
                e_val    = {8'h00, act_reg};
                e_last   = 1'b1;
            end
            default:
                emit_req = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psg_fs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            tgt_reg  <= e_tgt;
            och_reg  <= e_ch;
            off_reg  <= e_off;
            val_reg  <= e_val;
            last_reg <= e_last;
        end
    end

    // shared divider: 32 restoring steps
    always_ff @(posedge clk)
    begin
        if (state_reg == psg_fs_pkg::S_DMUL)
        begin
            quo_reg  <= mul_p[31:0];
            den_reg  <= is_noise_div ? {13'd0, src_clk_reg[23:15]} : src_clk_reg[23:2];
            rem_reg  <= 22'd0;
            dcnt_reg <= 5'd0;
        end
        else if (state_reg == psg_fs_pkg::S_DRUN)
        begin
            rem_reg  <= rem_step;
            quo_reg  <= {quo_reg[30:0], rem_ge};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_clk_reg   <= psg_fs_pkg::SRC_CLK_RESET;
            op_reg        <= 1'b0;
            addr_reg      <= 6'd0;
            data_reg      <= 8'd0;
            act_reg       <= 8'd0;
            ch_reg        <= 2'd0;
            idx_reg       <= 4'd0;
            sweep_set_reg <= 8'd0;
            noise_go_reg  <= 8'd0;
            wave_lvl_reg  <= 8'd0;
            pan_reg       <= 8'd0;
            master_reg    <= 8'd0;
            sweep_cnt_reg <= 3'd0;
            phase_reg     <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                len_set_reg[i] <= 8'd0;
                env_set_reg[i] <= 8'd0;
                len_cnt_reg[i] <= 8'd0;
                vol_reg[i]     <= 4'd0;
                env_cnt_reg[i] <= 3'd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                per_lo_reg[i] <= 8'd0;
                per_hi_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                src_clk_reg <= cfg_wr_data;
            case (state_reg)
                psg_fs_pkg::S_IDLE:
                    if (in_valid)
                    begin
                        op_reg   <= opcode;
                        addr_reg <= reg_addr;
                        data_reg <= reg_data;
                        act_reg  <= channel_ctrl_in;
                    end
                psg_fs_pkg::S_DEC:
                begin
                    ch_reg  <= dec_ch;
                    idx_reg <= 4'd0;
                    if (!op_reg)
                    begin
                        case (addr_reg)
                            psg_fs_pkg::A_SWEEP: sweep_set_reg  <= data_reg;
                            psg_fs_pkg::A_LEN0:  len_set_reg[0] <= data_reg;
                            psg_fs_pkg::A_LEN1:  len_set_reg[1] <= data_reg;
                            psg_fs_pkg::A_LEN2:  len_set_reg[2] <= data_reg;
                            psg_fs_pkg::A_LEN3:  len_set_reg[3] <= {2'b00, data_reg[5:0]};
                            psg_fs_pkg::A_ENV0:  env_set_reg[0] <= data_reg;
                            psg_fs_pkg::A_ENV1:  env_set_reg[1] <= data_reg;
                            psg_fs_pkg::A_ENV2:  env_set_reg[2] <= data_reg;
                            psg_fs_pkg::A_ENV3:  env_set_reg[3] <= data_reg;
                            psg_fs_pkg::A_WLVL:  wave_lvl_reg   <= data_reg;
                            psg_fs_pkg::A_PLO0:  per_lo_reg[0]  <= data_reg;
                            psg_fs_pkg::A_PLO1:  per_lo_reg[1]  <= data_reg;
                            psg_fs_pkg::A_PLO2:  per_lo_reg[2]  <= data_reg;
                            psg_fs_pkg::A_PHI0:  per_hi_reg[0]  <= data_reg;
                            psg_fs_pkg::A_PHI1:  per_hi_reg[1]  <= data_reg;
                            psg_fs_pkg::A_PHI2:  per_hi_reg[2]  <= data_reg;
                            psg_fs_pkg::A_NGO:   noise_go_reg   <= data_reg;
                            psg_fs_pkg::A_MVOL:  master_reg     <= data_reg;
                            psg_fs_pkg::A_PAN:   pan_reg        <= data_reg;
                            default: ;
                        endcase
                    end
                end
                psg_fs_pkg::S_ONE:
                    // output disable wipes all settings and channel state but the source clock
                    if (emit_fire && (addr_reg == psg_fs_pkg::A_ENABLE) && !data_reg[7])
                    begin
                        sweep_set_reg <= 8'd0;
                        noise_go_reg  <= 8'd0;
                        wave_lvl_reg  <= 8'd0;
                        pan_reg       <= 8'd0;
                        master_reg    <= 8'd0;
                        sweep_cnt_reg <= 3'd0;
                        phase_reg     <= 2'd0;
                        for (int i = 0; i < 4; i++)
                        begin
                            len_set_reg[i] <= 8'd0;
                            env_set_reg[i] <= 8'd0;
                            len_cnt_reg[i] <= 8'd0;
                            vol_reg[i]     <= 4'd0;
                            env_cnt_reg[i] <= 3'd0;
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            per_lo_reg[i] <= 8'd0;
                            per_hi_reg[i] <= 8'd0;
                        end
                    end
                psg_fs_pkg::S_MVOL:
                    if (emit_fire)
                        ch_reg <= ch_reg + 2'd1;
                psg_fs_pkg::S_WAVE:
                    if (emit_fire)
                        idx_reg <= idx_reg + 4'd1;
                psg_fs_pkg::S_TRIG:
                begin
                    if (len_cnt_reg[ch_reg] == 8'd0)
                        len_cnt_reg[ch_reg] <= (ch_reg == 2'd2) ? len_set_reg[ch_reg]
                                               : {2'b00, len_set_reg[ch_reg][5:0]};
                    vol_reg[ch_reg] <= (ch_reg == 2'd2) ? psg_fs_pkg::wave_vol(wave_lvl_reg[6:5])
                                                        : env_set_reg[ch_reg][7:4];
                    env_cnt_reg[ch_reg] <= 3'd0;
                    if (ch_reg == 2'd0)
                        sweep_cnt_reg <= 3'd0;
                end
                psg_fs_pkg::S_TLEN:
                begin
                    for (int i = 0; i < 4; i++)
                        len_cnt_reg[i] <= lc_new[i];
                    act_reg <= act_tl;
                    ch_reg  <= 2'd0;
                end
                psg_fs_pkg::S_ENV:
                begin
                    if (env_act)
                    begin
                        env_cnt_reg[ch_reg] <= env_match ? 3'd0 : cnt1;
                        if (env_match && env_up)
                            vol_reg[ch_reg] <= vol_reg[ch_reg] + 4'd1;
                        else if (env_match && env_dn)
                            vol_reg[ch_reg] <= vol_reg[ch_reg] - 4'd1;
                    end
                    if (!env_emit)
                        ch_reg <= env_next_ch;
                end
                psg_fs_pkg::S_EVOL:
                    if (emit_fire)
                        ch_reg <= env_next_ch;
                psg_fs_pkg::S_SWEEP:
                begin
                    ch_reg <= 2'd0;
                    if (sw_on)
                    begin
                        if (sw_over)
                            act_reg[0] <= 1'b0;
                        sweep_cnt_reg <= sw_match ? 3'd0 : sc1;
                        if (sw_match && !sw_over)
                        begin
                            per_lo_reg[0]      <= sw_np[7:0];
                            per_hi_reg[0][2:0] <= sw_np[10:8];
                        end
                    end
                end
                psg_fs_pkg::S_TEND:
                    if (emit_fire)
                        phase_reg <= phase_reg + 2'd1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted but block not busy");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && e_last |=> state_reg == psg_fs_pkg::S_IDLE)
        else $error("last command did not end the item");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == psg_fs_pkg::S_DRUN && dcnt_reg == 5'd31
        |=> state_reg == psg_fs_pkg::S_DEMIT)
        else $error("divider finished without emitting");

    a_tick_ends_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && e_last && op_reg |-> e_tgt == psg_fs_pkg::TGT_CHCTRL)
        else $error("tick did not end with a channel ctrl command");
`endif

endmodule

>>> dv/tb_psg_register_frame_sequencer.sv
// Self-checking testbench of the sound-register translator and frame sequencer.
`timescale 1ns / 1ps

module tb_psg_register_frame_sequencer;

    typedef struct packed {
        logic [2:0]  target;
        logic [1:0]  channel;
        logic [5:0]  wave_offset;
        logic [15:0] value;
        logic        last;
    } cmd_t;

    class cmd_scoreboard;
        logic [23:0] src_clk;
        logic [7:0]  sweep_set, noise_go, wave_lvl, pan, mvol, sweep_cnt;
        logic [7:0]  len_set [4];
        logic [7:0]  env_set [4];
        logic [7:0]  plo [3];
        logic [7:0]  phi [3];
        logic [7:0]  len_cnt [4];
        logic [7:0]  cur_vol [4];
        logic [7:0]  env_cnt [4];
        logic [1:0]  phase;
        cmd_t        pending[$];
        cmd_t        batch[$];
        int          mismatches;

        function void clear_state();
            sweep_set = 0; noise_go = 0; wave_lvl = 0; pan = 0; mvol = 0;
            sweep_cnt = 0; phase = 0;
            for (int i = 0; i < 4; i++)
            begin
                len_set[i] = 0; env_set[i] = 0; len_cnt[i] = 0;
                cur_vol[i] = 0; env_cnt[i] = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                plo[i] = 0; phi[i] = 0;
            end
        endfunction

        function void reset_all();
            src_clk = psg_fs_pkg::SRC_CLK_RESET;
            clear_state();
            mismatches = 0;
        endfunction

        function void push(logic [2:0] t, logic [1:0] c, logic [5:0] o, logic [15:0] v);
            cmd_t e;
            if (batch.size() >= 16)
                return;
            e.target = t; e.channel = c; e.wave_offset = o; e.value = v; e.last = 0;
            batch.push_back(e);
        endfunction

        function logic [15:0] sat_div(longint unsigned num, longint unsigned den);
            longint unsigned q;
            if (den == 0)
                return 16'hFFFF;
            q = num / den;
            return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        endfunction

        function void period_cmd(int idx);
            longint unsigned p;
            logic [15:0] d;
            p = {phi[idx][2:0], plo[idx]};
            d = sat_div(64'd1536000 * (2048 - p), src_clk >> 2);
            push(psg_fs_pkg::TGT_PERIOD, 2'(idx), 6'd0, 16'(17'h10000 - d));
        endfunction

        function void volume_cmd(int idx);
            int ml, mr, v;
            ml = pan[4 + idx] ? mvol[6:4] : 0;
            mr = pan[idx] ? mvol[2:0] : 0;
            v = cur_vol[idx][3:0];
            push(psg_fs_pkg::TGT_VOLUME, 2'(idx), 6'd0,
                 16'(((v * mr + 6) >> 3) | (((v * ml + 6) >> 3) << 4)));
        endfunction

        function void trigger(int idx, logic [7:0] chctrl);
            logic [7:0] mask;
            mask = 8'(1 << idx);
            if (len_cnt[idx] == 0)
                len_cnt[idx] = (idx == 2) ? len_set[idx] : (len_set[idx] & 8'h3F);
            if (idx == 2)
            begin
                case (wave_lvl[6:5])
                    2'd0: cur_vol[2] = 0;
                    2'd1: cur_vol[2] = 15;
                    2'd2: cur_vol[2] = 7;
                    default: cur_vol[2] = 3;
                endcase
            end
            else
                cur_vol[idx] = env_set[idx] >> 4;
            volume_cmd(idx);
            env_cnt[idx] = 0;
            if (idx == 0)
                sweep_cnt = 0;
            else if (idx == 3)
            begin
                mask |= 8'h80;
                push(psg_fs_pkg::TGT_NRESET, 2'd3, 6'd0, 16'd0);
            end
            push(psg_fs_pkg::TGT_CHCTRL, 2'(idx), 6'd0, {8'h00, chctrl | mask});
        endfunction

        function void env_step(logic [7:0] act, int idx);
            logic [7:0] en;
            en = env_set[idx];
            if (!act[idx] || en[2:0] == 0)
                return;
            env_cnt[idx] = (env_cnt[idx] + 1) & 7;
            if (env_cnt[idx] == en[2:0])
            begin
                if (en[3])
                begin
                    if (cur_vol[idx] < 15)
                    begin
                        cur_vol[idx]++; volume_cmd(idx);
                    end
                end
                else if (cur_vol[idx] > 0)
                begin
                    cur_vol[idx]--; volume_cmd(idx);
                end
                env_cnt[idx] = 0;
            end
        endfunction

        function void tick(logic [7:0] act);
            logic [7:0] en, wm;
            int p, d, np;
            logic over;
            for (int i = 0; i < 4; i++)
            begin
                en = (i < 3) ? phi[i] : noise_go;
                wm = (i == 2) ? 8'hFF : 8'h3F;
                if (act[i] && en[6])
                begin
                    if (len_cnt[i] != 0)
                        len_cnt[i] = (len_cnt[i] + 1) & wm;
                    if (len_cnt[i] == 0)
                        act[i] = 0;
                end
            end
            if (phase == 0)
            begin
                env_step(act, 0); env_step(act, 1); env_step(act, 3);
            end
            if (!phase[0] && (sweep_set & 8'h70) != 0)
            begin
                p = {phi[0][2:0], plo[0]};
                d = p >> sweep_set[2:0];
                np = sweep_set[3] ? p - d : p + d;
                over = (np >= 'h800) || (np < 0);
                if (over)
                    act[0] = 0;
                sweep_cnt = (sweep_cnt + 1) & 7;
                if (sweep_cnt == sweep_set[6:4])
                begin
                    if (!over)
                    begin
                        plo[0] = np[7:0];
                        phi[0] = {phi[0][7:3], np[10:8]};
                        period_cmd(0);
                    end
                    sweep_cnt = 0;
                end
            end
            push(psg_fs_pkg::TGT_CHCTRL, 2'd0, 6'd0, {8'h00, act});
            phase++;
        endfunction

        function void reg_write(logic [5:0] a, logic [7:0] dat, logic [7:0] chctrl);
            int idx;
            longint unsigned nclk;
            case (a)
                psg_fs_pkg::A_ENABLE:
                begin
                    push(psg_fs_pkg::TGT_OUTEN, 2'd0, 6'd0, {15'd0, dat[7]});
                    if (!dat[7])
                        clear_state();
                end
                psg_fs_pkg::A_PAN:
                begin
                    pan = dat;
                    for (int i = 0; i < 4; i++)
                        volume_cmd(i);
                end
                psg_fs_pkg::A_MVOL:
                begin
                    mvol = dat;
                    for (int i = 0; i < 4; i++)
                        volume_cmd(i);
                end
                psg_fs_pkg::A_SWEEP: sweep_set = dat;
                psg_fs_pkg::A_LEN0, psg_fs_pkg::A_LEN1:
                begin
                    idx = (a == psg_fs_pkg::A_LEN0) ? 0 : 1;
                    len_set[idx] = dat;
                    for (int i = 0; i < 16; i++)
                        push(psg_fs_pkg::TGT_WAVE, 2'(idx), 6'(idx * 16 + i),
                             {8'h00, psg_fs_pkg::duty_byte(dat[7:6], i[2:0])});
                end
                psg_fs_pkg::A_ENV0: env_set[0] = dat;
                psg_fs_pkg::A_ENV1: env_set[1] = dat;
                psg_fs_pkg::A_ENV2: env_set[2] = dat;
                psg_fs_pkg::A_ENV3: env_set[3] = dat;
                psg_fs_pkg::A_LEN2: len_set[2] = dat;
                psg_fs_pkg::A_LEN3: len_set[3] = dat & 8'h3F;
                psg_fs_pkg::A_WLVL: wave_lvl = dat;
                psg_fs_pkg::A_PLO0: begin plo[0] = dat; period_cmd(0); end
                psg_fs_pkg::A_PLO1: begin plo[1] = dat; period_cmd(1); end
                psg_fs_pkg::A_PLO2: begin plo[2] = dat; period_cmd(2); end
                psg_fs_pkg::A_PHI0, psg_fs_pkg::A_PHI1, psg_fs_pkg::A_PHI2:
                begin
                    idx = (a == psg_fs_pkg::A_PHI0) ? 0 : (a == psg_fs_pkg::A_PHI1) ? 1 : 2;
                    phi[idx] = dat;
                    period_cmd(idx);
                    if (dat[7])
                        trigger(idx, chctrl);
                end
                psg_fs_pkg::A_NPOLY:
                begin
                    nclk = longint'(psg_fs_pkg::noise_scale(dat[2:0])) << dat[7:4];
                    push(psg_fs_pkg::TGT_NCTRL, 2'd3, 6'd0, {15'h0008, dat[3]});
                    push(psg_fs_pkg::TGT_PERIOD, 2'd3, 6'd0,
                         16'(17'h10000 - sat_div(64'd1500 * nclk, src_clk >> 15)));
                end
                psg_fs_pkg::A_NGO:
                begin
                    noise_go = dat;
                    if (dat[7])
                        trigger(3, chctrl);
                end
                default:
                    if (a >= 6'h20 && a <= 6'h2F)
                        push(psg_fs_pkg::TGT_WAVE, 2'd2, a, {8'h00, dat[3:0], dat[7:4]});
            endcase
        endfunction

        function void note_item(logic op, logic [5:0] a, logic [7:0] dat, logic [7:0] chctrl);
            batch.delete();
            if (op)
                tick(chctrl);
            else
                reg_write(a, dat, chctrl);
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1;
            foreach (batch[i])
                pending.push_back(batch[i]);
        endfunction

        function void check_cmd(cmd_t got);
            cmd_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("cmd mismatch: exp tgt %0d ch %0d off %0d val %h last %0d",
                             e.target, e.channel, e.wave_offset, e.value, e.last);
                    $display("              got tgt %0d ch %0d off %0d val %h last %0d",
                             got.target, got.channel, got.wave_offset, got.value, got.last);
                end
            end
        endfunction
    endclass

    logic        clk, rst_n, cfg_wr_en, in_valid, in_stall, opcode, out_valid, out_stall, last;
    logic [23:0] cfg_wr_data;
    logic [5:0]  reg_addr, wave_offset;
    logic [7:0]  reg_data, channel_ctrl_in;
    logic [2:0]  target;
    logic [1:0]  channel;
    logic [15:0] value;

    cmd_scoreboard sb;
    int  cycles;
    bit  calm;          // no idling on either side
    int  hold_off;      // receiver hold-off still to run

    psg_register_frame_sequencer u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .reg_addr(reg_addr),
        .reg_data(reg_data), .channel_ctrl_in(channel_ctrl_in), .out_valid(out_valid),
        .out_stall(out_stall), .target(target), .channel(channel),
        .wave_offset(wave_offset), .value(value), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall && rst_n)
                sb.check_cmd({target, channel, wave_offset, value, last});
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 16);
        end
    end

    // valid stays up after an accept until the next item or an idle cycle
    task automatic send(logic op, logic [5:0] a, logic [7:0] dat, logic [7:0] chctrl);
        while (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; opcode <= op; reg_addr <= a; reg_data <= dat;
        channel_ctrl_in <= chctrl;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, a, dat, chctrl);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_clock(logic [23:0] hz);
        drain();
        cfg_wr_en <= 1; cfg_wr_data <= hz;
        @(posedge clk);
        sb.src_clk = hz;
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    task automatic rand_item();
        logic [5:0] a;
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send(1'b1, 6'($urandom), 8'($urandom), 8'($urandom));
        else
        begin
            if (r < 85)
            begin
                case ($urandom_range(7))
                    0: a = psg_fs_pkg::A_PHI0 + 6'($urandom_range(2)) * 6'd5;
                    1: a = psg_fs_pkg::A_NGO;
                    2: a = psg_fs_pkg::A_SWEEP;
                    3: a = 6'($urandom_range(psg_fs_pkg::A_ENV0, psg_fs_pkg::A_ENV3));
                    4: a = psg_fs_pkg::A_PLO0;
                    5: a = psg_fs_pkg::A_MVOL + 6'($urandom_range(1));
                    6: a = 6'h20 + 6'($urandom_range(15));
                    default: a = psg_fs_pkg::A_NPOLY;
                endcase
            end
            else
                a = 6'($urandom);
            // rare output disable so that state builds up
            if (a == psg_fs_pkg::A_ENABLE && $urandom_range(3) != 0)
                send(1'b0, a, 8'h80 | 8'($urandom), 8'($urandom));
            else
                send(1'b0, a, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_all();
        calm = 0; hold_off = 0;
        rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0; opcode = 0;
        reg_addr = 0; reg_data = 0; channel_ctrl_in = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, every register but PLO1 and PLO2, sweep/envelope edge cases
        send(0, psg_fs_pkg::A_MVOL, 8'h77, 8'h00);
        send(0, psg_fs_pkg::A_PAN, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_LEN0, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_LEN1, 8'h3F, 8'h00);
        send(0, psg_fs_pkg::A_ENV0, 8'hF1, 8'h00);
        send(0, psg_fs_pkg::A_ENV1, 8'h0F, 8'h00);
        send(0, psg_fs_pkg::A_PLO0, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_SWEEP, 8'h11, 8'h00);
        send(0, psg_fs_pkg::A_PHI0, 8'hC7, 8'hFF);
        send(0, psg_fs_pkg::A_PHI1, 8'hC0, 8'h00);
        send(0, psg_fs_pkg::A_WLVL, 8'h60, 8'h00);
        send(0, psg_fs_pkg::A_LEN2, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_ENV2, 8'hAA, 8'h00);
        send(0, psg_fs_pkg::A_PHI2, 8'hC3, 8'h55);
        send(0, psg_fs_pkg::A_LEN3, 8'h3F, 8'h00);
        send(0, psg_fs_pkg::A_ENV3, 8'h09, 8'h00);
        send(0, psg_fs_pkg::A_NPOLY, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_NGO, 8'hC0, 8'hAA);
        send(0, 6'h2F, 8'hA5, 8'h00);
        send(0, 6'h3F, 8'hFF, 8'h00);
        for (int i = 0; i < 9; i++)
            send(1, 6'h3F, 8'hFF, 8'hFF);
        send(0, psg_fs_pkg::A_ENABLE, 8'h00, 8'h00);
        send(0, psg_fs_pkg::A_ENABLE, 8'h80, 8'h00);

        // clock settings, extremes included
        set_clock(24'd131072);
        send(0, psg_fs_pkg::A_PLO0, 8'h00, 8'h00);
        send(0, psg_fs_pkg::A_NPOLY, 8'hF7, 8'h00);
        set_clock(24'd16777215);
        send(0, psg_fs_pkg::A_PLO1, 8'hFF, 8'h00);
        send(0, psg_fs_pkg::A_NPOLY, 8'h00, 8'h00);
        set_clock(24'd0);
        send(0, psg_fs_pkg::A_PLO2, 8'h10, 8'h00);
        set_clock(24'hFFFFFF);
        send(0, psg_fs_pkg::A_NPOLY, 8'h08, 8'h00);

        // receiver holds off while sender keeps offering
        hold_off = 400;
        for (int i = 0; i < 10; i++)
            send(0, psg_fs_pkg::A_LEN0, 8'($urandom), 8'h00);

        for (int i = 0; i < 200; i++)
        begin
            if (i == 60)
                calm = 1;
            if (i == 110)
                calm = 0;
            if (i == 150)
                set_clock(24'($urandom_range(131072, 16777215)));
            rand_item();
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
